FILE: hdl/llf_pkg.sv
// Package for the least-laxity-first scheduler: widths, codes and payload types.
// Used by llf_if, llf_eval and the top level; depends on nothing.
package llf_pkg;

  localparam int TIME_BITS     = 16;
  localparam int TW1           = TIME_BITS + 1;
  localparam int LAX_W         = TIME_BITS + 3;
  localparam int DEF_MAX_TASKS = 8;
  localparam int TASKS_W       = 4;
  localparam int IDX_FIELD_W   = 3;
  localparam int CFG_AW        = 3;
  localparam int CFG_DW        = 32;

  localparam logic [TIME_BITS-1:0] TMAX = {TIME_BITS{1'b1}};

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic [CFG_AW-3:0] REG_TASKS_IN_USE = '0;

  typedef logic [TIME_BITS-1:0]    time_t;
  typedef logic [TW1-1:0]          wtime_t;
  typedef logic signed [LAX_W-1:0] lax_t;

  typedef struct packed {
    time_t  period;
    time_t  deadline;
    time_t  work;
    time_t  remaining;
    wtime_t abs_deadline;
    wtime_t next_release;
  } task_word_t;

  typedef struct packed {
    logic                   opcode;
    logic [IDX_FIELD_W-1:0] task_index;
    time_t                  release_offset;
    time_t                  relative_deadline;
    time_t                  work_ticks;
    time_t                  release_period;
  } in_req_t;

  typedef struct packed {
    logic                   ran;
    logic [IDX_FIELD_W-1:0] run_task;
    logic                   job_done;
    logic                   deadline_miss;
    logic [IDX_FIELD_W-1:0] miss_task;
    time_t                  miss_time;
    logic                   halted;
  } out_rsp_t;

endpackage

FILE: hdl/llf_if.sv
// Valid/ready channel interfaces for the scheduler's request and result streams.
// Depends on llf_pkg for the payload types.
interface llf_in_if;
  logic             valid;
  logic             ready;
  llf_pkg::in_req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface llf_out_if;
  logic              valid;
  logic              ready;
  llf_pkg::out_rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: hdl/llf_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; holds the per-task entries of the scheduler.
module llf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/llf_eval.sv
// Shared per-task unit: release update, deadline-miss test, laxity and best compare.
// Applied to one task entry per cycle by the top level; depends on llf_pkg.
module llf_eval (
  input  llf_pkg::task_word_t word_i,
  input  llf_pkg::time_t      time_i,
  input  logic                best_valid_i,
  input  llf_pkg::lax_t       best_lax_i,
  output llf_pkg::task_word_t word_o,
  output logic                miss_o,
  output llf_pkg::lax_t       lax_o,
  output logic                better_o
);

  llf_pkg::wtime_t now_w;
  logic            release_hit;
  logic            pend;

  always_comb begin
    now_w       = {1'b0, time_i};
    release_hit = (word_i.next_release == now_w) && (word_i.remaining == '0);
    word_o      = word_i;
    if (release_hit) begin
      word_o.remaining    = word_i.work;
      word_o.abs_deadline = now_w + {1'b0, word_i.deadline};
      word_o.next_release = word_i.next_release + {1'b0, word_i.period};
    end
    pend     = (word_o.remaining != '0);
    miss_o   = pend && ((now_w + llf_pkg::TW1'(1)) > word_o.abs_deadline);
    lax_o    = $signed({2'b00, word_o.abs_deadline}) - $signed({3'b000, time_i})
             - $signed({3'b000, word_o.remaining});
    better_o = pend && (!best_valid_i || (lax_o < best_lax_i));
  end

endmodule

FILE: hdl/least_laxity_first_scheduler.sv
// Top level of the least-laxity-first scheduler: sequencer, APB register and output stage.
// Depends on llf_pkg, llf_if, llf_ram and llf_eval.
//
//   channel   direction  handshake          payload
//   in_ch     sink       valid/ready        in_req_t (load or tick request)
//   out_ch    source     valid/ready        out_rsp_t (one result per request)
//   APB       slave      psel/penable       tasks_in_use at byte address 0
//
// A load or a tick while halted goes from acceptance to the result state, whence
// the result is registered. A tick first scans the n active task entries: the shared
// evaluation unit visits one task entry per cycle through the entry RAM.
// Reset is synchronous and clears time, the halt flag and tasks_in_use.
// A waiting result does not block the next request; a stalled output holds
// the sequencer before it returns to idle.
module least_laxity_first_scheduler #(
  parameter int MAX_TASKS = llf_pkg::DEF_MAX_TASKS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  llf_in_if.sink                      in_ch,
  llf_out_if.source                   out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [llf_pkg::CFG_AW-1:0]  paddr,
  input  logic [llf_pkg::CFG_DW-1:0]  pwdata,
  output logic [llf_pkg::CFG_DW-1:0]  prdata,
  output logic                        pready
);

  localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNT_W = $clog2(MAX_TASKS + 1);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;
  localparam logic [1:0] ST_RESULT = 2'd3;

  logic [1:0]                   state_r, state_nxt;
  logic [llf_pkg::TASKS_W-1:0]  tasks_r, tasks_nxt;
  llf_pkg::time_t               time_r, time_nxt;
  logic                         stopped_r, stopped_nxt;
  logic [CNT_W-1:0]             scan_idx_r, scan_idx_nxt;
  logic                         proc_valid_r, proc_valid_nxt;
  logic [IDX_W-1:0]             proc_idx_r, proc_idx_nxt;
  logic                         miss_found_r, miss_found_nxt;
  logic [IDX_W-1:0]             miss_idx_r, miss_idx_nxt;
  logic                         best_valid_r, best_valid_nxt;
  llf_pkg::lax_t                best_lax_r, best_lax_nxt;
  logic [IDX_W-1:0]             best_idx_r, best_idx_nxt;
  llf_pkg::task_word_t          best_word_r, best_word_nxt;
  llf_pkg::out_rsp_t            res_r, res_nxt;
  logic                         out_valid_r, out_valid_nxt;
  llf_pkg::out_rsp_t            out_data_r, out_data_nxt;

  logic [CNT_W-1:0]     n_act;
  logic                 in_acc;
  logic                 issue;
  logic                 cfg_wr;
  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr;
  llf_pkg::task_word_t  ram_wdata;
  logic [IDX_W-1:0]     ram_raddr;
  llf_pkg::task_word_t  ram_rdata;
  llf_pkg::task_word_t  ev_word;
  logic                 ev_miss;
  llf_pkg::lax_t        ev_lax;
  logic                 ev_better;
  llf_pkg::time_t       time_inc;

  llf_ram #(
    .WIDTH ($bits(llf_pkg::task_word_t)),
    .DEPTH (MAX_TASKS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  llf_eval u_eval (
    .word_i       (ram_rdata),
    .time_i       (time_r),
    .best_valid_i (best_valid_r),
    .best_lax_i   (best_lax_r),
    .word_o       (ev_word),
    .miss_o       (ev_miss),
    .lax_o        (ev_lax),
    .better_o     (ev_better)
  );

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;
  assign pready       = 1'b1;
  assign cfg_wr       = psel && penable && pwrite;
  assign prdata       = (paddr[llf_pkg::CFG_AW-1:2] == llf_pkg::REG_TASKS_IN_USE) ?
                        llf_pkg::CFG_DW'(tasks_r) : '0;

  always_comb begin
    n_act     = (int'(tasks_r) > MAX_TASKS) ? CNT_W'(MAX_TASKS) : CNT_W'(tasks_r);
    in_acc    = in_ch.valid && (state_r == ST_IDLE);
    issue     = (scan_idx_r < n_act);
    ram_raddr = issue ? scan_idx_r[IDX_W-1:0] : '0;
    time_inc  = (time_r < llf_pkg::TMAX) ? (time_r + llf_pkg::TIME_BITS'(1)) : time_r;

    state_nxt      = state_r;
    tasks_nxt      = tasks_r;
    time_nxt       = time_r;
    stopped_nxt    = stopped_r;
    scan_idx_nxt   = scan_idx_r;
    proc_valid_nxt = proc_valid_r;
    proc_idx_nxt   = proc_idx_r;
    miss_found_nxt = miss_found_r;
    miss_idx_nxt   = miss_idx_r;
    best_valid_nxt = best_valid_r;
    best_lax_nxt   = best_lax_r;
    best_idx_nxt   = best_idx_r;
    best_word_nxt  = best_word_r;
    res_nxt        = res_r;
    out_data_nxt   = out_data_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    ram_we         = 1'b0;
    ram_waddr      = '0;
    ram_wdata      = ev_word;

    if (cfg_wr && (paddr[llf_pkg::CFG_AW-1:2] == llf_pkg::REG_TASKS_IN_USE)) begin
      tasks_nxt = pwdata[llf_pkg::TASKS_W-1:0];
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          res_nxt = '0;
          if (in_ch.data.opcode == llf_pkg::OP_LOAD) begin
            if (int'(in_ch.data.task_index) < MAX_TASKS) begin
              ram_we                 = 1'b1;
              ram_waddr              = IDX_W'(in_ch.data.task_index);
              ram_wdata.period       = in_ch.data.release_period;
              ram_wdata.deadline     = in_ch.data.relative_deadline;
              ram_wdata.work         = in_ch.data.work_ticks;
              ram_wdata.remaining    = '0;
              ram_wdata.next_release = {1'b0, in_ch.data.release_offset};
              ram_wdata.abs_deadline = {1'b0, in_ch.data.release_offset}
                                     + {1'b0, in_ch.data.relative_deadline};
            end
            time_nxt    = '0;
            stopped_nxt = 1'b0;
            state_nxt   = ST_RESULT;
          end else if (stopped_r) begin
            res_nxt.halted = 1'b1;
            state_nxt      = ST_RESULT;
          end else begin
            scan_idx_nxt   = '0;
            proc_valid_nxt = 1'b0;
            miss_found_nxt = 1'b0;
            best_valid_nxt = 1'b0;
            state_nxt      = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        proc_valid_nxt = issue;
        proc_idx_nxt   = scan_idx_r[IDX_W-1:0];
        if (issue) begin
          scan_idx_nxt = scan_idx_r + CNT_W'(1);
        end
        if (proc_valid_r) begin
          ram_we    = 1'b1;
          ram_waddr = proc_idx_r;
          ram_wdata = ev_word;
          if (ev_miss && !miss_found_r) begin
            miss_found_nxt = 1'b1;
            miss_idx_nxt   = proc_idx_r;
          end
          if (ev_better) begin
            best_valid_nxt = 1'b1;
            best_lax_nxt   = ev_lax;
            best_idx_nxt   = proc_idx_r;
            best_word_nxt  = ev_word;
          end
        end
        if (!issue) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        res_nxt = '0;
        if (miss_found_r) begin
          stopped_nxt           = 1'b1;
          res_nxt.deadline_miss = 1'b1;
          res_nxt.miss_task     = llf_pkg::IDX_FIELD_W'(miss_idx_r);
          res_nxt.miss_time     = time_r + llf_pkg::TIME_BITS'(1);
          res_nxt.halted        = 1'b1;
        end else begin
          if (best_valid_r) begin
            ram_we              = 1'b1;
            ram_waddr           = best_idx_r;
            ram_wdata           = best_word_r;
            ram_wdata.remaining = best_word_r.remaining - llf_pkg::TIME_BITS'(1);
            res_nxt.ran         = 1'b1;
            res_nxt.run_task    = llf_pkg::IDX_FIELD_W'(best_idx_r);
            res_nxt.job_done    = (best_word_r.remaining == llf_pkg::TIME_BITS'(1));
          end
          time_nxt       = time_inc;
          stopped_nxt    = (time_inc == llf_pkg::TMAX);
          res_nxt.halted = (time_inc == llf_pkg::TMAX);
        end
        state_nxt = ST_RESULT;
      end
      ST_RESULT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      tasks_r      <= '0;
      time_r       <= '0;
      stopped_r    <= 1'b0;
      scan_idx_r   <= '0;
      proc_valid_r <= 1'b0;
      miss_found_r <= 1'b0;
      best_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      tasks_r      <= tasks_nxt;
      time_r       <= time_nxt;
      stopped_r    <= stopped_nxt;
      scan_idx_r   <= scan_idx_nxt;
      proc_valid_r <= proc_valid_nxt;
      miss_found_r <= miss_found_nxt;
      best_valid_r <= best_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    proc_idx_r  <= proc_idx_nxt;
    miss_idx_r  <= miss_idx_nxt;
    best_lax_r  <= best_lax_nxt;
    best_idx_r  <= best_idx_nxt;
    best_word_r <= best_word_nxt;
    res_r       <= res_nxt;
    out_data_r  <= out_data_nxt;
  end

endmodule
